// ===== src/mlvn_pkg.sv =====
`timescale 1ns / 1ps
// mlvn_pkg: shared types and constants of the least-visited maze navigator.
// No dependencies.
package mlvn_pkg;

	localparam int MAZE_SIZE_DEF  = 32;
	localparam int COUNT_BITS_DEF = 8;
	localparam int POS_BITS       = 5;
	localparam int RUN_BITS       = 4;

	localparam logic [RUN_BITS-1:0] RUN_MAX      = 4'd15;
	localparam logic [RUN_BITS-1:0] FINISH_RESET = 4'd3;

	localparam logic [1:0] ACT_LEFT    = 2'd0;
	localparam logic [1:0] ACT_FORWARD = 2'd1;
	localparam logic [1:0] ACT_RIGHT   = 2'd2;
	localparam logic [1:0] ACT_AROUND  = 2'd3;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_EAST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	localparam logic [1:0] TURN_LEFT  = 2'd3;
	localparam logic [1:0] TURN_RIGHT = 2'd1;
	localparam logic [1:0] TURN_BACK  = 2'd2;

	typedef struct packed {
		logic wall_left;
		logic wall_forward;
		logic wall_right;
	} in_t;

	typedef struct packed {
		logic [1:0]          action;
		logic                finished;
		logic [POS_BITS-1:0] pos_x;
		logic [POS_BITS-1:0] pos_y;
		logic [1:0]          heading;
	} out_t;

endpackage

// ===== src/mlvn_nbr.sv =====
`timescale 1ns / 1ps
// mlvn_nbr: neighbor cell of a grid position in a given direction, with an
// on-grid flag. Depends on mlvn_pkg.
module mlvn_nbr import mlvn_pkg::*; #(
	parameter int MAZE_SIZE = MAZE_SIZE_DEF,
	localparam int CW = $clog2(MAZE_SIZE)
) (
	input  logic [CW-1:0] x,
	input  logic [CW-1:0] y,
	input  logic [1:0]    dir,
	output logic [CW-1:0] nx,
	output logic [CW-1:0] ny,
	output logic          ok
);

	localparam logic [CW-1:0] LAST = CW'(MAZE_SIZE - 1);

	always_comb begin
		nx = x;
		ny = y;
		ok = 1'b0;
		case (dir)
			DIR_NORTH: begin
				ok = (y != LAST);
				ny = y + 1'b1;
			end
			DIR_EAST: begin
				ok = (x != LAST);
				nx = x + 1'b1;
			end
			DIR_SOUTH: begin
				ok = (y != '0);
				ny = y - 1'b1;
			end
			DIR_WEST: begin
				ok = (x != '0);
				nx = x - 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/mlvn_visit_mem.sv =====
`timescale 1ns / 1ps
// mlvn_visit_mem: visit-count memory, one write and one registered read port,
// with a zero-fill sweep after reset. Depends on mlvn_pkg.
module mlvn_visit_mem import mlvn_pkg::*; #(
	parameter int MAZE_SIZE  = MAZE_SIZE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int DEPTH = MAZE_SIZE * MAZE_SIZE,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [COUNT_BITS-1:0] wr_data,
	input  logic [AW-1:0]         rd_addr,
	output logic [COUNT_BITS-1:0] rd_data,
	output logic                  clr_busy
);

	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rd_data_q;
	logic [AW-1:0]         clr_addr_q;
	logic                  clr_busy_q;
	logic                  we;
	logic [AW-1:0]         wa;
	logic [COUNT_BITS-1:0] wd;

	assign we       = clr_busy_q || wr_en;
	assign wa       = clr_busy_q ? clr_addr_q : wr_addr;
	assign wd       = clr_busy_q ? '0 : wr_data;
	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

// ===== src/mlvn_decide.sv =====
`timescale 1ns / 1ps
// mlvn_decide: least-visited side choice, new heading and new position.
// Depends on mlvn_pkg and mlvn_nbr.
module mlvn_decide import mlvn_pkg::*; #(
	parameter int MAZE_SIZE  = MAZE_SIZE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int CW = $clog2(MAZE_SIZE)
) (
	input  logic [CW-1:0]         cur_x,
	input  logic [CW-1:0]         cur_y,
	input  logic [1:0]            cur_hd,
	input  in_t                   walls,
	input  logic [COUNT_BITS-1:0] cnt_l,
	input  logic [COUNT_BITS-1:0] cnt_f,
	input  logic [COUNT_BITS-1:0] cnt_r,
	output logic [1:0]            act,
	output logic [1:0]            new_hd,
	output logic [CW-1:0]         new_x,
	output logic [CW-1:0]         new_y
);

	localparam logic [COUNT_BITS:0] BLOCKED = {1'b1, {COUNT_BITS{1'b0}}};

	logic [1:0]          hl, hf, hr;
	logic [CW-1:0]       nx_l, ny_l, nx_f, ny_f, nx_r, ny_r;
	logic                ok_l, ok_f, ok_r;
	logic                bl, bf, br;
	logic [COUNT_BITS:0] cl, cf, cr;

	assign hl = cur_hd + TURN_LEFT;
	assign hf = cur_hd;
	assign hr = cur_hd + TURN_RIGHT;

	mlvn_nbr #(.MAZE_SIZE(MAZE_SIZE)) u_nbr_l (
		.x(cur_x), .y(cur_y), .dir(hl), .nx(nx_l), .ny(ny_l), .ok(ok_l)
	);
	mlvn_nbr #(.MAZE_SIZE(MAZE_SIZE)) u_nbr_f (
		.x(cur_x), .y(cur_y), .dir(hf), .nx(nx_f), .ny(ny_f), .ok(ok_f)
	);
	mlvn_nbr #(.MAZE_SIZE(MAZE_SIZE)) u_nbr_r (
		.x(cur_x), .y(cur_y), .dir(hr), .nx(nx_r), .ny(ny_r), .ok(ok_r)
	);

	assign bl = walls.wall_left || !ok_l;
	assign bf = walls.wall_forward || !ok_f;
	assign br = walls.wall_right || !ok_r;
	assign cl = bl ? BLOCKED : {1'b0, cnt_l};
	assign cf = bf ? BLOCKED : {1'b0, cnt_f};
	assign cr = br ? BLOCKED : {1'b0, cnt_r};

	always_comb begin
		if (!bl && cl <= cf && cl <= cr) begin
			act    = ACT_LEFT;
			new_hd = hl;
			new_x  = nx_l;
			new_y  = ny_l;
		end else if (!bf && cf <= cr) begin
			act    = ACT_FORWARD;
			new_hd = hf;
			new_x  = nx_f;
			new_y  = ny_f;
		end else if (!br) begin
			act    = ACT_RIGHT;
			new_hd = hr;
			new_x  = nx_r;
			new_y  = ny_r;
		end else begin
			act    = ACT_AROUND;
			new_hd = cur_hd + TURN_BACK;
			new_x  = cur_x;
			new_y  = cur_y;
		end
	end

endmodule

// ===== src/maze_least_visited_navigator.sv =====
`timescale 1ns / 1ps
// maze_least_visited_navigator: Tremaux-style least-visited maze explorer.
// Each input passes ST_IDLE, ST_RD_L, ST_RD_F, ST_DECIDE: left, forward and right neighbor counts
// are read through the visit memory's single read port, then the decide result is registered.
// A new input is taken only back in ST_IDLE, also while a result still waits on out_stall.
// Reset: position, heading, run cleared; visit memory zero-filled over all MAZE_SIZE*MAZE_SIZE
// cells (1024 by default), in_stall high. Uses mlvn_pkg, mlvn_nbr, mlvn_visit_mem, mlvn_decide.
module maze_least_visited_navigator import mlvn_pkg::*; #(
	parameter int MAZE_SIZE  = MAZE_SIZE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_t                 in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_t                out_data,
	input  logic                cfg_we,
	input  logic [RUN_BITS-1:0] cfg_wdata
);

	localparam int CW    = $clog2(MAZE_SIZE);
	localparam int DEPTH = MAZE_SIZE * MAZE_SIZE;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_L,
		ST_RD_F,
		ST_DECIDE
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         cur_x_q, cur_y_q;
	logic [1:0]            cur_hd_q;
	logic [RUN_BITS-1:0]   run_q;
	logic [RUN_BITS-1:0]   finish_q;
	logic [COUNT_BITS-1:0] cur_count_q;
	logic [COUNT_BITS-1:0] cl_q, cf_q;
	in_t                   walls_q;
	logic                  out_valid_q;
	out_t                  out_q;

	logic                  clr_busy;
	logic                  in_xfer, dec_go;
	logic [1:0]            rd_dir;
	logic [CW-1:0]         rd_x, rd_y;
	logic                  rd_ok;
	logic [AW-1:0]         cur_addr, rd_addr;
	logic [COUNT_BITS-1:0] rd_data, cnt_inc, next_count;
	logic [1:0]            dec_act, dec_hd;
	logic [CW-1:0]         dec_x, dec_y;
	logic [RUN_BITS-1:0]   run_nx;

	assign in_stall  = (state_q != ST_IDLE) || clr_busy;
	assign in_xfer   = in_valid && !in_stall;
	assign dec_go    = (state_q == ST_DECIDE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cur_addr = AW'(cur_x_q) * AW'(MAZE_SIZE) + AW'(cur_y_q);
	assign cnt_inc  = (cur_count_q == '1) ? cur_count_q : cur_count_q + 1'b1;

	always_comb begin
		case (state_q)
			ST_IDLE: rd_dir = cur_hd_q + TURN_LEFT;
			ST_RD_L: rd_dir = cur_hd_q;
			default: rd_dir = cur_hd_q + TURN_RIGHT;
		endcase
	end

	mlvn_nbr #(.MAZE_SIZE(MAZE_SIZE)) u_nbr_rd (
		.x(cur_x_q), .y(cur_y_q), .dir(rd_dir), .nx(rd_x), .ny(rd_y), .ok(rd_ok)
	);

	// off-grid side reads the current cell; its value is ignored as blocked
	assign rd_addr = rd_ok ? AW'(rd_x) * AW'(MAZE_SIZE) + AW'(rd_y) : cur_addr;

	mlvn_visit_mem #(.MAZE_SIZE(MAZE_SIZE), .COUNT_BITS(COUNT_BITS)) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(in_xfer),
		.wr_addr(cur_addr),
		.wr_data(cnt_inc),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.clr_busy(clr_busy)
	);

	mlvn_decide #(.MAZE_SIZE(MAZE_SIZE), .COUNT_BITS(COUNT_BITS)) u_decide (
		.cur_x(cur_x_q),
		.cur_y(cur_y_q),
		.cur_hd(cur_hd_q),
		.walls(walls_q),
		.cnt_l(cl_q),
		.cnt_f(cf_q),
		.cnt_r(rd_data),
		.act(dec_act),
		.new_hd(dec_hd),
		.new_x(dec_x),
		.new_y(dec_y)
	);

	always_comb begin
		case (dec_act)
			ACT_LEFT:    next_count = cl_q;
			ACT_FORWARD: next_count = cf_q;
			ACT_RIGHT:   next_count = rd_data;
			default:     next_count = cur_count_q;
		endcase
	end

	assign run_nx = (dec_act == ACT_RIGHT) ?
		((run_q == RUN_MAX) ? run_q : run_q + 1'b1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_hd_q    <= DIR_NORTH;
			run_q       <= '0;
			finish_q    <= FINISH_RESET;
			cur_count_q <= '0;
			cl_q        <= '0;
			cf_q        <= '0;
			walls_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				finish_q <= cfg_wdata;
			end
			if (dec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						walls_q     <= in_data;
						cur_count_q <= cnt_inc;
						state_q     <= ST_RD_L;
					end
				end
				ST_RD_L: begin
					cl_q    <= rd_data;
					state_q <= ST_RD_F;
				end
				ST_RD_F: begin
					cf_q    <= rd_data;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (dec_go) begin
						cur_x_q        <= dec_x;
						cur_y_q        <= dec_y;
						cur_hd_q       <= dec_hd;
						run_q          <= run_nx;
						cur_count_q    <= next_count;
						out_q.action   <= dec_act;
						out_q.finished <= (run_nx == finish_q);
						out_q.pos_x    <= POS_BITS'(dec_x);
						out_q.pos_y    <= POS_BITS'(dec_y);
						out_q.heading  <= dec_hd;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !clr_busy)
		else $error("input transfer during memory clear");

	a_xfer_starts_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_RD_L)
		else $error("transfer did not start neighbor reads");

	a_around_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_go && dec_act == ACT_AROUND) |=>
		(cur_x_q == $past(cur_x_q) && cur_y_q == $past(cur_y_q)))
		else $error("turn-around moved the position");

	a_finished_matches_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.finished == (run_q == finish_q))
		else $error("finished flag disagrees with right-turn run");

endmodule

// ===== test/maze_least_visited_navigator_test.sv =====
`timescale 1ns / 1ps
// maze_least_visited_navigator_test: self-checking bench for the least-visited maze navigator.
// Drives wall readings with random idling, predicts each move, checks each result.
// Depends on mlvn_pkg and maze_least_visited_navigator.
module maze_least_visited_navigator_test;
	import mlvn_pkg::*;

	localparam int GRID      = MAZE_SIZE_DEF;
	localparam int COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;
	localparam int BLOCKED   = 1 << COUNT_BITS_DEF;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_t                 in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_t                out_data;
	logic                cfg_we = 1'b0;
	logic [RUN_BITS-1:0] cfg_wdata = '0;

	maze_least_visited_navigator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mouse model
	logic [COUNT_BITS_DEF-1:0] visits [GRID][GRID];
	logic [POS_BITS-1:0]       mouse_x, mouse_y;
	logic [1:0]                mouse_hdg;
	logic [RUN_BITS-1:0]       right_run;
	logic [RUN_BITS-1:0]       finish_cnt;

	in_t  pending_walls[$];
	out_t expected_moves[$];

	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	bit  in_taken = 1'b0;
	int  errors = 0;
	int  moves_sent = 0;
	int  results_checked = 0;
	int  finish_flags = 0;
	int  turnarounds = 0;

	function automatic bit step_to(input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y,
			input logic [1:0] d, output logic [POS_BITS-1:0] nx, output logic [POS_BITS-1:0] ny);
		bit ok;
		ok = 1'b1;
		nx = x;
		ny = y;
		case (d)
			DIR_NORTH: begin
				if (int'(y) + 1 >= GRID) ok = 1'b0;
				else ny = y + 1'b1;
			end
			DIR_EAST: begin
				if (int'(x) + 1 >= GRID) ok = 1'b0;
				else nx = x + 1'b1;
			end
			DIR_SOUTH: begin
				if (y == '0) ok = 1'b0;
				else ny = y - 1'b1;
			end
			default: begin
				if (x == '0) ok = 1'b0;
				else nx = x - 1'b1;
			end
		endcase
		return ok;
	endfunction

	function automatic int side_cost(logic wall, logic [1:0] d);
		logic [POS_BITS-1:0] nx, ny;
		if (wall) return BLOCKED;
		if (!step_to(mouse_x, mouse_y, d, nx, ny)) return BLOCKED;
		return int'(visits[nx][ny]);
	endfunction

	function automatic out_t advance_mouse(in_t w);
		logic [1:0]          hl, hf, hr, nh, act;
		logic [POS_BITS-1:0] nx, ny;
		int                  cl, cf, cr;
		out_t                r;
		hl = mouse_hdg + TURN_LEFT;
		hf = mouse_hdg;
		hr = mouse_hdg + TURN_RIGHT;
		if (int'(visits[mouse_x][mouse_y]) < COUNT_MAX)
			visits[mouse_x][mouse_y] = visits[mouse_x][mouse_y] + 1'b1;
		cl = side_cost(w.wall_left, hl);
		cf = side_cost(w.wall_forward, hf);
		cr = side_cost(w.wall_right, hr);
		if (cl != BLOCKED && cl <= cf && cl <= cr) begin
			act = ACT_LEFT;
			nh = hl;
		end else if (cf != BLOCKED && cf <= cr) begin
			act = ACT_FORWARD;
			nh = hf;
		end else if (cr != BLOCKED) begin
			act = ACT_RIGHT;
			nh = hr;
		end else begin
			act = ACT_AROUND;
			nh = mouse_hdg + TURN_BACK;
		end
		if (act == ACT_RIGHT) begin
			if (right_run != RUN_MAX) right_run = right_run + 1'b1;
		end else begin
			right_run = '0;
		end
		mouse_hdg = nh;
		if (act != ACT_AROUND && step_to(mouse_x, mouse_y, nh, nx, ny)) begin
			mouse_x = nx;
			mouse_y = ny;
		end
		r.action   = act;
		r.finished = (right_run == finish_cnt);
		r.pos_x    = mouse_x;
		r.pos_y    = mouse_y;
		r.heading  = mouse_hdg;
		return r;
	endfunction

	function automatic in_t walls(bit l, bit f, bit r);
		in_t w;
		w.wall_left    = l;
		w.wall_forward = f;
		w.wall_right   = r;
		return w;
	endfunction

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_walls.size() != 0 && !chance(tx_idle_pct)) begin
				in_data  <= pending_walls.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= chance(rx_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		out_t want;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			expected_moves.push_back(advance_mouse(in_data));
			moves_sent++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_moves.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: act=%0d fin=%0b x=%0d y=%0d hdg=%0d",
					out_data.action, out_data.finished, out_data.pos_x, out_data.pos_y,
					out_data.heading);
			end else begin
				want = expected_moves.pop_front();
				if (out_data.action !== want.action || out_data.finished !== want.finished ||
						out_data.pos_x !== want.pos_x || out_data.pos_y !== want.pos_y ||
						out_data.heading !== want.heading) begin
					errors++;
					if (errors <= 10) begin
						$display("move %0d mismatch: expected act=%0d fin=%0b x=%0d y=%0d hdg=%0d",
							results_checked, want.action, want.finished, want.pos_x,
							want.pos_y, want.heading);
						$display("  got act=%0d fin=%0b x=%0d y=%0d hdg=%0d", out_data.action,
							out_data.finished, out_data.pos_x, out_data.pos_y,
							out_data.heading);
					end
				end
				if (want.finished) finish_flags++;
				if (want.action == ACT_AROUND) turnarounds++;
				results_checked++;
			end
		end
	end

	task automatic set_finish(logic [RUN_BITS-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		finish_cnt = v;
	endtask

	task automatic drain();
		while (pending_walls.size() != 0 || in_valid || expected_moves.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// wandering with wall density changing every 16 moves
	task automatic load_wander(int n);
		int dens;
		dens = 30;
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0) begin
				case ($urandom_range(3))
					0: dens = 5;
					1: dens = 30;
					2: dens = 60;
					default: dens = 90;
				endcase
			end
			pending_walls.push_back(walls(chance(dens), chance(dens), chance(dens)));
		end
	endtask

	initial begin
		logic [RUN_BITS-1:0] mid_cnt;
		for (int x = 0; x < GRID; x++)
			for (int y = 0; y < GRID; y++)
				visits[x][y] = '0;
		mouse_x    = '0;
		mouse_y    = '0;
		mouse_hdg  = DIR_NORTH;
		right_run  = '0;
		finish_cnt = FINISH_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 34;
		rx_idle_pct = 73;
		// up three cells, then circle right until the run saturates
		repeat (3) pending_walls.push_back(walls(1'b1, 1'b0, 1'b1));
		repeat (17) pending_walls.push_back(walls(1'b1, 1'b1, 1'b0));
		for (int i = 0; i < 8; i++)
			pending_walls.push_back(in_t'(i));
		load_wander(450);
		drain();

		tx_idle_pct = 73;
		rx_idle_pct = 34;
		set_finish(RUN_MAX);
		// boxed in long enough to saturate the cell count
		repeat (270) pending_walls.push_back(walls(1'b1, 1'b1, 1'b1));
		for (int i = 0; i < 200; i++)
			pending_walls.push_back(walls(chance(85), chance(85), chance(15)));
		drain();

		set_finish(4'd1);
		load_wander(450);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_finish(4'd0);
		load_wander(300);
		drain();

		mid_cnt = RUN_BITS'($urandom_range(14, 2));
		set_finish(mid_cnt);
		load_wander(300);
		drain();

		if (expected_moves.size() != 0) begin
			errors += expected_moves.size();
			$display("%0d expected results never arrived", expected_moves.size());
		end
		$display("%0d moves checked over finish counts 3, 15, 1, 0 and %0d", results_checked,
			mid_cnt);
		$display("%0d finish flags, %0d turn-arounds, %0d mismatches", finish_flags, turnarounds,
			errors);
		if (errors == 0) begin
			$display("maze_least_visited_navigator_test: PASS");
		end else begin
			$display("maze_least_visited_navigator_test: FAIL");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("timeout after %0d moves", moves_sent);
		$display("maze_least_visited_navigator_test: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mlvn_pkg.sv
src/mlvn_nbr.sv
src/mlvn_visit_mem.sv
src/mlvn_decide.sv
src/maze_least_visited_navigator.sv
test/maze_least_visited_navigator_test.sv
